// ----- rtl/core/ptq_pkg.sv -----
// Package with shared types and constants for the presence trigger qualifier.
`timescale 1ns / 1ps
`default_nettype none

package ptq_pkg;

    localparam int unsigned LimitW = 11;
    localparam int unsigned CountW = 24;
    localparam int unsigned DistW = 12;
    localparam int unsigned AddrW = 4;
    localparam int unsigned DataW = 32;

    localparam logic [CountW-1:0] COUNT_MAX = {CountW{1'b1}};

    typedef enum logic [1:0] {
        KIND_TICK    = 2'd0,
        KIND_TRIGGER = 2'd1,
        KIND_REPORT  = 2'd2,
        KIND_INIT    = 2'd3
    } t_kind;

    typedef enum logic [1:0] {
        ZONE_CLEAR  = 2'd0,
        ZONE_NEAR   = 2'd1,
        ZONE_MIDDLE = 2'd2,
        ZONE_FAR    = 2'd3
    } t_zone;

    typedef enum logic [1:0] {
        REG_ZONE_ONE = 2'd0,
        REG_ZONE_TWO = 2'd1,
        REG_TIMEOUT  = 2'd2
    } t_reg_index;

    typedef struct packed {
        logic [LimitW-1:0] zone_one_limit_cm;
        logic [LimitW-1:0] zone_two_limit_cm;
        logic [CountW-1:0] inactivity_timeout_ms;
    } t_cfg;

    localparam logic [LimitW-1:0] ZONE_ONE_RESET = 11'd100;
    localparam logic [LimitW-1:0] ZONE_TWO_RESET = 11'd250;
    localparam logic [CountW-1:0] TIMEOUT_RESET = 24'd30000;

endpackage

`default_nettype wire

// ----- rtl/core/ptq_if.sv -----
// Item channel interfaces for the input and result sides.
`timescale 1ns / 1ps
`default_nettype none

interface ptq_in_if;
    logic                       valid;
    logic                       ready;
    logic [1:0]                 kind;
    logic signed [11:0]         target_distance_cm;
    logic                       init_ok;

    modport source (output valid, output kind, output target_distance_cm, output init_ok,
                    input ready);
    modport sink (input valid, input kind, input target_distance_cm, input init_ok,
                  output ready);
endinterface

interface ptq_out_if;
    logic       valid;
    logic       ready;
    logic       event_valid;
    logic [1:0] zone;
    logic       occupied;
    logic       zone_known;
    logic       radar_power_on;
    logic       refresh_request;

    modport source (output valid, output event_valid, output zone, output occupied,
                    output zone_known, output radar_power_on, output refresh_request,
                    input ready);
    modport sink (input valid, input event_valid, input zone, input occupied,
                  input zone_known, input radar_power_on, input refresh_request,
                  output ready);
endinterface

`default_nettype wire

// ----- rtl/core/ptq_cfg_regs.sv -----
// APB configuration registers for zone limits and the inactivity timeout.
`timescale 1ns / 1ps
`default_nettype none

module ptq_cfg_regs (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [ptq_pkg::AddrW-1:0]     paddr,
    input  wire logic [ptq_pkg::DataW-1:0]     pwdata,
    output logic      [ptq_pkg::DataW-1:0]     prdata,
    output logic                               pready,
    output ptq_pkg::t_cfg                      o_cfg
);

    ptq_pkg::t_cfg        r_cfg;
    logic                 wr_en;
    ptq_pkg::t_reg_index  reg_sel;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite && pready;
    assign reg_sel = ptq_pkg::t_reg_index'(paddr[3:2]);
    assign o_cfg   = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.zone_one_limit_cm     <= ptq_pkg::ZONE_ONE_RESET;
            r_cfg.zone_two_limit_cm     <= ptq_pkg::ZONE_TWO_RESET;
            r_cfg.inactivity_timeout_ms <= ptq_pkg::TIMEOUT_RESET;
        end else if (wr_en) begin
            case (reg_sel)
                ptq_pkg::REG_ZONE_ONE: begin
                    r_cfg.zone_one_limit_cm <= pwdata[ptq_pkg::LimitW-1:0];
                end
                ptq_pkg::REG_ZONE_TWO: begin
                    r_cfg.zone_two_limit_cm <= pwdata[ptq_pkg::LimitW-1:0];
                end
                ptq_pkg::REG_TIMEOUT: begin
                    r_cfg.inactivity_timeout_ms <= pwdata[ptq_pkg::CountW-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        prdata = '0;
        case (reg_sel)
            ptq_pkg::REG_ZONE_ONE: begin
                prdata = ptq_pkg::DataW'(r_cfg.zone_one_limit_cm);
            end
            ptq_pkg::REG_ZONE_TWO: begin
                prdata = ptq_pkg::DataW'(r_cfg.zone_two_limit_cm);
            end
            ptq_pkg::REG_TIMEOUT: begin
                prdata = ptq_pkg::DataW'(r_cfg.inactivity_timeout_ms);
            end
            default: begin
                prdata = '0;
            end
        endcase
    end

endmodule

`default_nettype wire

// ----- rtl/core/ptq_core.sv -----
// Input register, presence state update and result register.
`timescale 1ns / 1ps
`default_nettype none

module ptq_core (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  ptq_pkg::t_cfg      i_cfg,
    ptq_in_if.sink             i_in,
    ptq_out_if.source          o_out
);

    // Input register.
    logic                           r_in_valid;
    ptq_pkg::t_kind                 r_kind;
    logic [ptq_pkg::DistW-1:0]      r_dist;
    logic                           r_init_ok;

    // Presence state.
    logic                           r_active;
    ptq_pkg::t_zone                 r_zone;
    logic [ptq_pkg::CountW-1:0]     r_count;

    // Result register.
    logic                           r_out_valid;
    logic                           r_ev;
    ptq_pkg::t_zone                 r_out_zone;
    logic                           r_occ;
    logic                           r_known;
    logic                           r_power;
    logic                           r_refresh;

    logic                           advance;
    logic                           in_take;
    logic                           n_active;
    ptq_pkg::t_zone                 n_zone;
    logic [ptq_pkg::CountW-1:0]     n_count;
    logic                           n_ev;
    ptq_pkg::t_zone                 n_out_zone;
    logic                           n_occ;
    logic                           n_known;
    logic                           n_refresh;
    logic [ptq_pkg::CountW-1:0]     count_inc;
    ptq_pkg::t_zone                 report_zone;

    assign advance    = r_in_valid && (!r_out_valid || o_out.ready);
    assign i_in.ready = !r_in_valid || advance;
    assign in_take    = i_in.valid && i_in.ready;

    assign o_out.valid           = r_out_valid;
    assign o_out.event_valid     = r_ev;
    assign o_out.zone            = r_out_zone;
    assign o_out.occupied        = r_occ;
    assign o_out.zone_known      = r_known;
    assign o_out.radar_power_on  = r_power;
    assign o_out.refresh_request = r_refresh;

    assign count_inc = (r_count == ptq_pkg::COUNT_MAX) ? r_count
                                                       : r_count + 1'b1;

    always_comb begin
        if (r_dist[ptq_pkg::DistW-1]) begin
            report_zone = ptq_pkg::ZONE_CLEAR;
        end else if (r_dist[ptq_pkg::LimitW-1:0] < i_cfg.zone_one_limit_cm) begin
            report_zone = ptq_pkg::ZONE_NEAR;
        end else if (r_dist[ptq_pkg::LimitW-1:0] < i_cfg.zone_two_limit_cm) begin
            report_zone = ptq_pkg::ZONE_MIDDLE;
        end else begin
            report_zone = ptq_pkg::ZONE_FAR;
        end
    end

    always_comb begin
        n_active   = r_active;
        n_zone     = r_zone;
        n_count    = r_count;
        n_ev       = 1'b0;
        n_out_zone = ptq_pkg::ZONE_CLEAR;
        n_occ      = 1'b0;
        n_known    = 1'b0;
        n_refresh  = 1'b0;
        if (!r_active) begin
            if (r_kind == ptq_pkg::KIND_TRIGGER) begin
                n_active  = 1'b1;
                n_count   = '0;
                n_zone    = ptq_pkg::ZONE_CLEAR;
                n_ev      = 1'b1;
                n_occ     = 1'b1;
                n_refresh = 1'b1;
            end
        end else begin
            case (r_kind)
                ptq_pkg::KIND_TICK: begin
                    n_count = count_inc;
                    if (count_inc > i_cfg.inactivity_timeout_ms) begin
                        n_active = 1'b0;
                        n_zone   = ptq_pkg::ZONE_CLEAR;
                        n_count  = '0;
                        n_ev     = 1'b1;
                        n_known  = 1'b1;
                    end
                end
                ptq_pkg::KIND_TRIGGER: begin
                    n_count = '0;
                end
                ptq_pkg::KIND_REPORT: begin
                    n_count = '0;
                    if (report_zone != r_zone) begin
                        n_zone     = report_zone;
                        n_ev       = 1'b1;
                        n_out_zone = report_zone;
                        n_occ      = 1'b1;
                        n_known    = 1'b1;
                    end
                end
                ptq_pkg::KIND_INIT: begin
                    if (!r_init_ok) begin
                        n_active = 1'b0;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_active    <= 1'b0;
            r_zone      <= ptq_pkg::ZONE_CLEAR;
            r_count     <= '0;
        end else begin
            if (in_take) begin
                r_in_valid <= 1'b1;
            end else if (advance) begin
                r_in_valid <= 1'b0;
            end
            if (advance) begin
                r_out_valid <= 1'b1;
                r_active    <= n_active;
                r_zone      <= n_zone;
                r_count     <= n_count;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_kind    <= ptq_pkg::t_kind'(i_in.kind);
            r_dist    <= i_in.target_distance_cm;
            r_init_ok <= i_in.init_ok;
        end
        if (advance) begin
            r_ev       <= n_ev;
            r_out_zone <= n_out_zone;
            r_occ      <= n_occ;
            r_known    <= n_known;
            r_power    <= n_active;
            r_refresh  <= n_refresh;
        end
    end

`ifndef NO_ASSERTIONS
    a_refresh_is_wakeup: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_refresh |-> r_ev && r_occ && !r_known && r_power)
        else $error("refresh request without a wake-up event");

    a_quiet_result_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && !r_ev |-> r_out_zone == ptq_pkg::ZONE_CLEAR && !r_occ && !r_known)
        else $error("result without event carries nonzero fields");

    a_vacancy_powers_off: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_ev && !r_occ |-> !r_power && !r_active && r_count == '0)
        else $error("vacancy posted while the rail stays on");

    a_power_tracks_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        advance |=> r_power == r_active)
        else $error("rail command differs from the presence state");
`endif

endmodule

`default_nettype wire

// ----- rtl/core/presence_trigger_qualifier_fsm.sv -----
// Top level of the presence trigger qualifier.
// Channel   Direction  Handshake      Payload
// i_in      in         valid/ready    kind, target_distance_cm, init_ok
// o_out     out        valid/ready    event_valid, zone, occupied, zone_known,
//                                     radar_power_on, refresh_request
// apb       in         psel/penable   paddr, pwdata, prdata (pready always high)
// Each item passes through the input register and then the result register.
// One item is accepted per cycle while the result register is not stalled; the state update is combinational.
// Reset is synchronous on i_rst_n and returns the valid flags, presence state and configuration to their defaults.
// A stalled result register holds a full input register, which holds i_in.ready low.
`timescale 1ns / 1ps
`default_nettype none

module presence_trigger_qualifier_fsm (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    ptq_in_if.sink                             i_in,
    ptq_out_if.source                          o_out,
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [ptq_pkg::AddrW-1:0]     paddr,
    input  wire logic [ptq_pkg::DataW-1:0]     pwdata,
    output logic      [ptq_pkg::DataW-1:0]     prdata,
    output logic                               pready
);

    ptq_pkg::t_cfg cfg;

    ptq_cfg_regs u_cfg_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    ptq_core u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (cfg),
        .i_in    (i_in),
        .o_out   (o_out)
    );

endmodule

`default_nettype wire
